[hw/rtl/vlr_pkg.sv]
`timescale 1ns / 1ps

package vlr_pkg;

    // Default chunk height.
    localparam int DEPTH_DEFAULT = 128;

    // Chunk plane edge and largest plane coordinate.
    localparam int PLANE_SIZE = 16;
    localparam logic [3:0] PLANE_MAX = 4'd15;

    // Write counter value at the last of the at most sixteen writes one line request can cause.
    localparam logic [3:0] LAST_COUNT = 4'd15;

    // Rotation codes.
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CCW  = 2'd1;
    localparam logic [1:0] ROT_CW   = 2'd2;
    localparam logic [1:0] ROT_HALF = 2'd3;

    // Micro-operations.
    localparam logic [1:0] OP_ACCEPT = 2'd0;
    localparam logic [1:0] OP_ROTATE = 2'd1;
    localparam logic [1:0] OP_SETUP  = 2'd2;
    localparam logic [1:0] OP_EMIT   = 2'd3;

    // Jump conditions: when true, go to the target step, else to the next one.
    localparam logic [1:0] COND_NEVER  = 2'd0;
    localparam logic [1:0] COND_ALWAYS = 2'd1;
    localparam logic [1:0] COND_NO_IN  = 2'd2;
    localparam logic [1:0] COND_MORE   = 2'd3;

    // Step numbers.
    localparam logic [2:0] STEP_ACCEPT = 3'd0;
    localparam logic [2:0] STEP_ROTATE = 3'd1;
    localparam logic [2:0] STEP_SETUP  = 3'd2;
    localparam logic [2:0] STEP_EMIT   = 3'd3;
    localparam logic [2:0] STEP_RETURN = 3'd4;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
        logic [1:0]         start_rotation;
        logic [1:0]         end_rotation;
        logic [7:0]         block_value;
    } line_req_t;

    typedef struct packed {
        logic [14:0] write_address;
        logic [7:0]  fill_value;
        logic [3:0]  cell_x;
        logic [6:0]  cell_y;
        logic [3:0]  cell_z;
        logic        last_write;
    } cell_write_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] cond;
        logic [2:0] target;
    } ctrl_t;

    // Control store: one control word per step.
    function automatic ctrl_t ucode_rom(input logic [2:0] step);
        ctrl_t w;
        case (step)
            STEP_ACCEPT: w = '{op: OP_ACCEPT, cond: COND_NO_IN,  target: STEP_ACCEPT};
            STEP_ROTATE: w = '{op: OP_ROTATE, cond: COND_NEVER,  target: STEP_ACCEPT};
            STEP_SETUP:  w = '{op: OP_SETUP,  cond: COND_NEVER,  target: STEP_ACCEPT};
            STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_MORE,   target: STEP_EMIT};
            STEP_RETURN: w = '{op: OP_SETUP,  cond: COND_ALWAYS, target: STEP_ACCEPT};
            default:     w = '{op: OP_SETUP,  cond: COND_ALWAYS, target: STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/vlr_endpoint.sv]
`timescale 1ns / 1ps

module vlr_endpoint
    import vlr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int YW = $clog2(DEPTH)
) (
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    input  logic [1:0]         rotation,
    output logic [3:0]         pt_x,
    output logic [3:0]         pt_z,
    output logic [YW-1:0]      pt_y
);

    localparam logic signed [16:0] YMAX = 17'(DEPTH - 1);
    localparam logic signed [15:0] XZMAX = 16'(PLANE_SIZE - 1);

    logic [3:0] cx;
    logic [3:0] cz;

    // Clamp into the chunk.
    always_comb begin
        if (raw_x < 0) begin
            cx = '0;
        end else if (raw_x > XZMAX) begin
            cx = PLANE_MAX;
        end else begin
            cx = raw_x[3:0];
        end
        if (raw_z < 0) begin
            cz = '0;
        end else if (raw_z > XZMAX) begin
            cz = PLANE_MAX;
        end else begin
            cz = raw_z[3:0];
        end
        if (raw_y < 0) begin
            pt_y = '0;
        end else if (17'(raw_y) > YMAX) begin
            pt_y = YMAX[YW-1:0];
        end else begin
            pt_y = raw_y[YW-1:0];
        end
    end

    // Rotate in the plane; 15 - v is the bitwise complement on four bits.
    always_comb begin
        case (rotation)
            ROT_CCW: begin
                pt_x = cz;
                pt_z = ~cx;
            end
            ROT_CW: begin
                pt_x = ~cz;
                pt_z = cx;
            end
            ROT_HALF: begin
                pt_x = ~cx;
                pt_z = ~cz;
            end
            default: begin
                pt_x = cx;
                pt_z = cz;
            end
        endcase
    end

endmodule

[hw/rtl/voxel_line_rasterizer_top.sv]
`timescale 1ns / 1ps
// A taken request passes the rotate and setup steps before emit registers its first write.
// A line of n cells (1 to 16) runs the microcode program: accept, rotate, setup,
// n emit steps, return.
// A request is taken only at the accept step; a stall on the result side holds the emit step.
// Reset (aresetn low, synchronous) returns the step counter to accept and drops m_valid.

module voxel_line_rasterizer_top
    import vlr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  line_req_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output cell_write_t m_data
);

    localparam int YW = $clog2(DEPTH);
    // The height error term also has to hold the plane span, which reaches fifteen.
    localparam int YEW = ((YW > 4) ? YW : 4) + 3;

    ctrl_t ctrl;

    logic [2:0] pc_reg, pc_next;
    logic       m_valid_reg, m_valid_next;
    cell_write_t m_data_reg;
    line_req_t  req_reg;

    // Endpoint values after clamp and rotation.
    logic [3:0]    sx_w, sz_w, ex_w, ez_w;
    logic [YW-1:0] sy_w, ey_w;

    // Walk registers.
    logic [3:0]    sx_reg, sz_reg, ex_reg, ez_reg;
    logic [YW-1:0] sy_reg, ey_reg;
    logic [3:0]    dx_reg, dz_reg;
    logic [YW-1:0] dy_reg;
    logic [3:0]    yopp_reg;
    logic          stx_reg, stz_reg, sty_reg;
    logic signed [6:0]     err_reg;
    logic signed [YEW-1:0] yerr_reg;
    logic [3:0]    cnt_reg;

    logic out_free;
    logic is_last;
    logic out_load;
    logic jump;

    logic signed [7:0]   e2;
    logic signed [7:0]   dx_s, dz_s;
    logic                x_move, z_move;
    logic signed [6:0]   err_next;
    logic signed [YEW:0] ye2;
    logic signed [YEW:0] yopp_s, dy_s;
    logic                y_move, y_add;
    logic signed [YEW-1:0] yerr_next;
    logic [YW-1:0]       sy_next;
    logic [16:0]         addr;

    // Setup values.
    logic [3:0]    dx_w, dz_w;
    logic [YW-1:0] dy_w;

    assign ctrl = ucode_rom(pc_reg);

    // Endpoint clamp and rotation units.
    vlr_endpoint #(.DEPTH(DEPTH)) u_start (
        .raw_x    (req_reg.start_x),
        .raw_y    (req_reg.start_y),
        .raw_z    (req_reg.start_z),
        .rotation (req_reg.start_rotation),
        .pt_x     (sx_w),
        .pt_z     (sz_w),
        .pt_y     (sy_w)
    );

    vlr_endpoint #(.DEPTH(DEPTH)) u_end (
        .raw_x    (req_reg.end_x),
        .raw_y    (req_reg.end_y),
        .raw_z    (req_reg.end_z),
        .rotation (req_reg.end_rotation),
        .pt_x     (ex_w),
        .pt_z     (ez_w),
        .pt_y     (ey_w)
    );

    // Handshake and emit conditions.
    assign s_ready  = (ctrl.op == OP_ACCEPT);
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = ((sx_reg == ex_reg) && (sz_reg == ez_reg)) || (cnt_reg == LAST_COUNT);
    assign out_load = (ctrl.op == OP_EMIT) && out_free;

    // Sequencer: conditional jump or fall through.
    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS: jump = 1'b1;
            COND_NO_IN:  jump = !s_valid;
            COND_MORE:   jump = !(out_free && is_last);
            default:     jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 3'd1;
    end

    // Deltas for setup.
    always_comb begin
        dx_w = (sx_reg < ex_reg) ? ex_reg - sx_reg : sx_reg - ex_reg;
        dz_w = (sz_reg < ez_reg) ? ez_reg - sz_reg : sz_reg - ez_reg;
        dy_w = (sy_reg < ey_reg) ? ey_reg - sy_reg : sy_reg - ey_reg;
    end

    // Plane and height error terms for one walk step.
    always_comb begin
        dx_s     = 8'($signed({1'b0, dx_reg}));
        dz_s     = 8'($signed({1'b0, dz_reg}));
        e2       = 8'(err_reg) <<< 1;
        x_move   = e2 > -dz_s;
        z_move   = e2 < dx_s;
        err_next = 7'(8'(err_reg) - (x_move ? dz_s : 8'sd0) + (z_move ? dx_s : 8'sd0));

        yopp_s    = (YEW + 1)'($signed({1'b0, yopp_reg}));
        dy_s      = (YEW + 1)'($signed({1'b0, dy_reg}));
        ye2       = (YEW + 1)'(yerr_reg) <<< 1;
        y_move    = (sy_reg != ey_reg) && (ye2 > -yopp_s);
        y_add     = (sy_reg != ey_reg) && (ye2 < dy_s);
        yerr_next = YEW'((YEW + 1)'(yerr_reg) - (y_move ? yopp_s : '0)
                         + (y_add ? dy_s : '0));
        sy_next   = y_move ? (sty_reg ? sy_reg + 1'b1 : sy_reg - 1'b1) : sy_reg;
    end

    // Column-major cell address.
    assign addr = 17'({sx_reg, sz_reg}) * 17'(DEPTH) + 17'(sy_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath, driven by the current micro-operation.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    req_reg <= s_data;
                end
            end
            OP_ROTATE: begin
                sx_reg <= sx_w;
                sz_reg <= sz_w;
                sy_reg <= sy_w;
                ex_reg <= ex_w;
                ez_reg <= ez_w;
                ey_reg <= ey_w;
            end
            OP_SETUP: begin
                dx_reg   <= dx_w;
                dz_reg   <= dz_w;
                dy_reg   <= dy_w;
                stx_reg  <= sx_reg < ex_reg;
                stz_reg  <= sz_reg < ez_reg;
                sty_reg  <= sy_reg < ey_reg;
                err_reg  <= 7'($signed({1'b0, dx_w})) - 7'($signed({1'b0, dz_w}));
                yopp_reg <= (dz_w > dx_w) ? dz_w : dx_w;
                yerr_reg <= YEW'($signed({1'b0, dy_w}))
                            - YEW'($signed({1'b0, ((dz_w > dx_w) ? dz_w : dx_w)}));
                cnt_reg  <= '0;
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_data_reg.write_address <= addr[14:0];
                    m_data_reg.fill_value    <= req_reg.block_value;
                    m_data_reg.cell_x        <= sx_reg;
                    m_data_reg.cell_y        <= 7'(sy_reg);
                    m_data_reg.cell_z        <= sz_reg;
                    m_data_reg.last_write    <= is_last;
                    cnt_reg  <= cnt_reg + 4'd1;
                    err_reg  <= err_next;
                    yerr_reg <= yerr_next;
                    sy_reg   <= sy_next;
                    if (x_move) begin
                        sx_reg <= stx_reg ? sx_reg + 4'd1 : sx_reg - 4'd1;
                    end
                    if (z_move) begin
                        sz_reg <= stz_reg ? sz_reg + 4'd1 : sz_reg - 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A new request is never taken right after one was taken.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while a line is in progress");

    // A write that is not the last keeps the sequencer in the emit step.
    a_emit_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !is_last |=> pc_reg == STEP_EMIT)
        else $error("line ended before its last write");

    // The last write returns the sequencer toward accept.
    a_last_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && is_last |=> pc_reg == STEP_RETURN)
        else $error("sequencer kept emitting after the last write");

    // The write count of a line never passes sixteen.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_EMIT) && (cnt_reg == LAST_COUNT) |-> is_last)
        else $error("line longer than sixteen cells");

endmodule
